>>> rtl/dual_wheel_pi_speed_controller_defines.svh
// ----------------------------------------------------------------------------
// Dual-wheel PI speed controller: assertion macros
// Shared property forms for the checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef DUAL_WHEEL_PI_SPEED_CONTROLLER_DEFINES_SVH
`define DUAL_WHEEL_PI_SPEED_CONTROLLER_DEFINES_SVH

// condition holds at every edge out of reset
`define DWPI_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define DWPI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/dwpi_pkg.sv
// ----------------------------------------------------------------------------
// dwpi_pkg
// Types, widths and constants of the dual-wheel PI speed controller.
// ----------------------------------------------------------------------------
package dwpi_pkg;

    localparam int BASE_W     = 7;
    localparam int ANGLE_W    = 10;
    localparam int GAIN_W     = 8;
    localparam int LIMIT_W    = 14;
    localparam int MEAS_W     = 10;
    localparam int DRIVE_W    = 15;
    localparam int GOAL_W     = 8;
    localparam int ACC_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    localparam int ERR_W  = 11;
    localparam int DIFF_W = 12;
    localparam int PROD_W = 21;
    localparam int NUM_W  = 23;
    localparam int DEN_W  = 17;
    localparam int QUO_W  = 3;
    localparam int TGT_W  = 9;

    localparam int SPEED_MIN    = 25;
    localparam int SPEED_MAX    = 38;
    localparam int DEAD_BAND    = 15;
    localparam int OFFSET_MAX   = 5;
    localparam int OFS_NUM_BIAS = 200;
    localparam int OFS_DEN_BIAS = 20200;

    localparam int BASE_SPEED_RST   = 26;
    localparam int STEER_CENTER_RST = 512;
    localparam int GAIN_P_RST       = 25;
    localparam int GAIN_I_RST       = 40;
    localparam int DRIVE_LIMIT_RST  = 9900;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_SPEED   = 3'd0,
        REG_STEER_CENTER = 3'd1,
        REG_GAIN_P_LEFT  = 3'd2,
        REG_GAIN_I_LEFT  = 3'd3,
        REG_GAIN_P_RIGHT = 3'd4,
        REG_GAIN_I_RIGHT = 3'd5,
        REG_DRIVE_LIMIT  = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_STOP    = 2'd0,
        MODE_REVERSE = 2'd1,
        MODE_FORWARD = 2'd2,
        MODE_HOLD    = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OFS_MUL,
        ST_OFS_DIV,
        ST_TARGET,
        ST_ERR,
        ST_MUL_PL,
        ST_MUL_IL,
        ST_MUL_PR,
        ST_MUL_IR,
        ST_MUL_END,
        ST_ACC,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        MUL_P_LEFT,
        MUL_I_LEFT,
        MUL_P_RIGHT,
        MUL_I_RIGHT
    } mul_sel_t;

    typedef enum logic [2:0] {
        DU_HOLD,
        DU_LOAD_L,
        DU_ADD_L,
        DU_LOAD_R,
        DU_ADD_R
    } du_op_t;

    typedef struct packed {
        logic [BASE_W-1:0]  base_speed;
        logic [ANGLE_W-1:0] steer_center;
        logic [GAIN_W-1:0]  gain_p_left;
        logic [GAIN_W-1:0]  gain_i_left;
        logic [GAIN_W-1:0]  gain_p_right;
        logic [GAIN_W-1:0]  gain_i_right;
        logic [LIMIT_W-1:0] drive_limit;
    } dwpi_cfg_t;

    typedef struct packed {
        logic     load_in;
        logic     ofs_mul;
        logic     div_step;
        logic     set_target;
        logic     calc_err;
        mul_sel_t mul_sel;
        du_op_t   du_op;
        logic     acc_upd;
        logic     load_out;
    } dwpi_cmd_t;

    typedef struct packed {
        logic div_done;
    } dwpi_sts_t;

endpackage

>>> rtl/dual_wheel_pi_speed_controller.sv
// ----------------------------------------------------------------------------
// dual_wheel_pi_speed_controller
// Two-wheel incremental PI speed loop with steering differential.
//
//   channel  direction  handshake          payload
//   s_       in         s_valid/s_ready    run_mode, steer_angle, meas L/R
//   m_       out        m_valid/m_ready    drive L/R, goal L/R
//   cfg_     in         cfg_we (no wait)   cfg_index, cfg_wdata
//
// One beat at a time: each tick runs the offset subtract loop (0 to 5 steps)
// and the shared PI multiplier (4 products).
// Result is held in an output register; a stalled m_ready delays the next
// s_ready only while a finished result is still waiting there.
// aresetn is synchronous; it restores register defaults and clears the
// targets, last errors and accumulators.
// ----------------------------------------------------------------------------
module dual_wheel_pi_speed_controller
    import dwpi_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_run_mode,
    input  logic [ANGLE_W-1:0]        s_steer_angle,
    input  logic signed [MEAS_W-1:0]  s_meas_left,
    input  logic signed [MEAS_W-1:0]  s_meas_right,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [DRIVE_W-1:0] m_drive_left,
    output logic signed [DRIVE_W-1:0] m_drive_right,
    output logic signed [GOAL_W-1:0]  m_goal_left,
    output logic signed [GOAL_W-1:0]  m_goal_right
);

    dwpi_cfg_t cfg;
    dwpi_cmd_t cmd;
    dwpi_sts_t sts;

    dwpi_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    dwpi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    dwpi_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .cmd           (cmd),
        .sts           (sts),
        .s_run_mode    (s_run_mode),
        .s_steer_angle (s_steer_angle),
        .s_meas_left   (s_meas_left),
        .s_meas_right  (s_meas_right),
        .m_drive_left  (m_drive_left),
        .m_drive_right (m_drive_right),
        .m_goal_left   (m_goal_left),
        .m_goal_right  (m_goal_right)
    );

endmodule

>>> rtl/dwpi_cfg.sv
// ----------------------------------------------------------------------------
// dwpi_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module dwpi_cfg
    import dwpi_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output dwpi_cfg_t             cfg
);

    dwpi_cfg_t cfg_reg;
    dwpi_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_BASE_SPEED:   cfg_next.base_speed   = cfg_wdata[BASE_W-1:0];
                REG_STEER_CENTER: cfg_next.steer_center = cfg_wdata[ANGLE_W-1:0];
                REG_GAIN_P_LEFT:  cfg_next.gain_p_left  = cfg_wdata[GAIN_W-1:0];
                REG_GAIN_I_LEFT:  cfg_next.gain_i_left  = cfg_wdata[GAIN_W-1:0];
                REG_GAIN_P_RIGHT: cfg_next.gain_p_right = cfg_wdata[GAIN_W-1:0];
                REG_GAIN_I_RIGHT: cfg_next.gain_i_right = cfg_wdata[GAIN_W-1:0];
                REG_DRIVE_LIMIT:  cfg_next.drive_limit  = cfg_wdata[LIMIT_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.base_speed   <= BASE_W'(BASE_SPEED_RST);
            cfg_reg.steer_center <= ANGLE_W'(STEER_CENTER_RST);
            cfg_reg.gain_p_left  <= GAIN_W'(GAIN_P_RST);
            cfg_reg.gain_i_left  <= GAIN_W'(GAIN_I_RST);
            cfg_reg.gain_p_right <= GAIN_W'(GAIN_P_RST);
            cfg_reg.gain_i_right <= GAIN_W'(GAIN_I_RST);
            cfg_reg.drive_limit  <= LIMIT_W'(DRIVE_LIMIT_RST);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/dwpi_ctrl.sv
// ----------------------------------------------------------------------------
// dwpi_ctrl
// Tick sequencer: steps the datapath through offset, targets, PI and output.
// ----------------------------------------------------------------------------
module dwpi_ctrl
    import dwpi_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  dwpi_sts_t sts,
    output dwpi_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (s_valid) state_next = ST_OFS_MUL;
            ST_OFS_MUL: state_next = ST_OFS_DIV;
            ST_OFS_DIV: if (sts.div_done) state_next = ST_TARGET;
            ST_TARGET:  state_next = ST_ERR;
            ST_ERR:     state_next = ST_MUL_PL;
            ST_MUL_PL:  state_next = ST_MUL_IL;
            ST_MUL_IL:  state_next = ST_MUL_PR;
            ST_MUL_PR:  state_next = ST_MUL_IR;
            ST_MUL_IR:  state_next = ST_MUL_END;
            ST_MUL_END: state_next = ST_ACC;
            ST_ACC:     state_next = ST_DONE;
            ST_DONE:    if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            ST_OFS_MUL: cmd.ofs_mul    = 1'b1;
            ST_OFS_DIV: cmd.div_step   = !sts.div_done;
            ST_TARGET:  cmd.set_target = 1'b1;
            ST_ERR:     cmd.calc_err   = 1'b1;
            ST_MUL_PL:  cmd.mul_sel    = MUL_P_LEFT;
            ST_MUL_IL: begin
                cmd.mul_sel = MUL_I_LEFT;
                cmd.du_op   = DU_LOAD_L;
            end
            ST_MUL_PR: begin
                cmd.mul_sel = MUL_P_RIGHT;
                cmd.du_op   = DU_ADD_L;
            end
            ST_MUL_IR: begin
                cmd.mul_sel = MUL_I_RIGHT;
                cmd.du_op   = DU_LOAD_R;
            end
            ST_MUL_END: cmd.du_op    = DU_ADD_R;
            ST_ACC:     cmd.acc_upd  = 1'b1;
            ST_DONE:    cmd.load_out = out_free;
            default:    cmd          = '0;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

>>> rtl/dwpi_dp.sv
// ----------------------------------------------------------------------------
// dwpi_dp
// Datapath: steering offset with bounded subtract divider, wheel targets,
// shared PI multiplier, clamped accumulators and result registers.
// ----------------------------------------------------------------------------
`include "dual_wheel_pi_speed_controller_defines.svh"

module dwpi_dp
    import dwpi_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  dwpi_cfg_t                cfg,
    input  dwpi_cmd_t                cmd,
    output dwpi_sts_t                sts,
    input  logic [1:0]               s_run_mode,
    input  logic [ANGLE_W-1:0]       s_steer_angle,
    input  logic signed [MEAS_W-1:0] s_meas_left,
    input  logic signed [MEAS_W-1:0] s_meas_right,
    output logic signed [DRIVE_W-1:0] m_drive_left,
    output logic signed [DRIVE_W-1:0] m_drive_right,
    output logic signed [GOAL_W-1:0]  m_goal_left,
    output logic signed [GOAL_W-1:0]  m_goal_right
);

    function automatic logic signed [GOAL_W-1:0] clamp_speed(logic signed [TGT_W-1:0] v);
        logic signed [GOAL_W-1:0] r;
        if (v <= TGT_W'(SPEED_MIN)) begin
            r = GOAL_W'(SPEED_MIN);
        end else if (v >= TGT_W'(SPEED_MAX)) begin
            r = GOAL_W'(SPEED_MAX);
        end else begin
            r = v[GOAL_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [ACC_W-1:0] acc_clamp(logic signed [ACC_W-1:0] acc,
                                                          logic [ACC_W-1:0] du,
                                                          logic signed [ACC_W-1:0] lim);
        logic signed [ACC_W-1:0] sum;
        logic signed [ACC_W-1:0] r;
        sum = acc + $signed(du);
        if (sum >= lim) begin
            r = lim;
        end else if (sum <= -lim) begin
            r = -lim;
        end else begin
            r = sum;
        end
        return r;
    endfunction

    // input beat
    mode_t                     mode_reg;
    logic [ANGLE_W-1:0]        angle_reg;
    logic signed [MEAS_W-1:0]  meas_l_reg;
    logic signed [MEAS_W-1:0]  meas_r_reg;

    // offset
    logic                      e_big_reg;
    logic                      steer_lt_reg;
    logic                      steer_gt_reg;
    logic [NUM_W-1:0]          rem_reg;
    logic [DEN_W-1:0]          den_reg;
    logic [QUO_W-1:0]          quo_reg;

    // loop state
    logic signed [GOAL_W-1:0]  target_l_reg;
    logic signed [GOAL_W-1:0]  target_r_reg;
    logic signed [ERR_W-1:0]   last_err_l_reg;
    logic signed [ERR_W-1:0]   last_err_r_reg;
    logic signed [ACC_W-1:0]   accum_l_reg;
    logic signed [ACC_W-1:0]   accum_r_reg;

    // PI working registers
    logic signed [ERR_W-1:0]   err_l_reg;
    logic signed [ERR_W-1:0]   err_r_reg;
    logic signed [DIFF_W-1:0]  diff_l_reg;
    logic signed [DIFF_W-1:0]  diff_r_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [ACC_W-1:0]          du_l_reg;
    logic [ACC_W-1:0]          du_r_reg;

    // result beat
    logic signed [DRIVE_W-1:0] drive_l_reg;
    logic signed [DRIVE_W-1:0] drive_r_reg;
    logic signed [GOAL_W-1:0]  goal_l_reg;
    logic signed [GOAL_W-1:0]  goal_r_reg;

    logic signed [ANGLE_W:0]   dev;
    logic [ANGLE_W-1:0]        dev_abs;
    logic [DEN_W-1:0]          e_ext;
    logic [DEN_W-1:0]          e_x45;
    logic [DEN_W-1:0]          num_fac;
    logic [DEN_W-1:0]          ofs_den;
    logic [NUM_W-1:0]          ofs_num;

    logic [QUO_W-1:0]          off;
    logic signed [TGT_W-1:0]   base_s;
    logic signed [TGT_W-1:0]   off_s;
    logic signed [TGT_W-1:0]   tl_raw;
    logic signed [TGT_W-1:0]   tr_raw;

    logic signed [ERR_W-1:0]   err_l;
    logic signed [ERR_W-1:0]   err_r;

    logic [GAIN_W-1:0]         mul_a;
    logic signed [DIFF_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]  mul_res;
    logic signed [ACC_W-1:0]   lim_s;

    // steering deviation and offset fraction terms
    assign dev     = $signed({1'b0, angle_reg}) - $signed({1'b0, cfg.steer_center});
    assign dev_abs = dev[ANGLE_W] ? ANGLE_W'(-dev) : dev[ANGLE_W-1:0];
    assign e_ext   = DEN_W'(dev_abs);
    assign e_x45   = (e_ext << 5) + (e_ext << 3) + (e_ext << 2) + e_ext;
    assign num_fac = e_x45 + DEN_W'(OFS_NUM_BIAS);
    assign ofs_den = e_x45 + DEN_W'(OFS_DEN_BIAS);
    assign ofs_num = NUM_W'(cfg.base_speed) * NUM_W'(num_fac);

    assign sts.div_done = (rem_reg < NUM_W'(den_reg)) || (quo_reg == QUO_W'(OFFSET_MAX));

    // wheel targets
    assign off    = e_big_reg ? quo_reg : '0;
    assign base_s = $signed(TGT_W'(cfg.base_speed));
    assign off_s  = $signed(TGT_W'(off));
    assign tl_raw = steer_lt_reg ? base_s + off_s :
                    steer_gt_reg ? base_s - off_s : base_s;
    assign tr_raw = steer_lt_reg ? base_s - off_s :
                    steer_gt_reg ? base_s + off_s : base_s;

    assign err_l = ERR_W'(target_l_reg) - ERR_W'(meas_l_reg);
    assign err_r = ERR_W'(target_r_reg) - ERR_W'(meas_r_reg);

    // shared multiplier
    always_comb begin
        case (cmd.mul_sel)
            MUL_P_LEFT: begin
                mul_a = cfg.gain_p_left;
                mul_b = diff_l_reg;
            end
            MUL_I_LEFT: begin
                mul_a = cfg.gain_i_left;
                mul_b = DIFF_W'(err_l_reg);
            end
            MUL_P_RIGHT: begin
                mul_a = cfg.gain_p_right;
                mul_b = diff_r_reg;
            end
            default: begin
                mul_a = cfg.gain_i_right;
                mul_b = DIFF_W'(err_r_reg);
            end
        endcase
    end

    assign mul_res = PROD_W'($signed({1'b0, mul_a})) * PROD_W'(mul_b);
    assign lim_s   = $signed(ACC_W'(cfg.drive_limit));

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            mode_reg   <= mode_t'(s_run_mode);
            angle_reg  <= s_steer_angle;
            meas_l_reg <= s_meas_left;
            meas_r_reg <= s_meas_right;
        end
        if (cmd.ofs_mul) begin
            e_big_reg    <= dev_abs > ANGLE_W'(DEAD_BAND);
            steer_lt_reg <= dev[ANGLE_W];
            steer_gt_reg <= !dev[ANGLE_W] && (dev != '0);
            rem_reg      <= ofs_num;
            den_reg      <= ofs_den;
        end else if (cmd.div_step) begin
            rem_reg <= rem_reg - NUM_W'(den_reg);
        end
        if (cmd.calc_err) begin
            err_l_reg  <= err_l;
            err_r_reg  <= err_r;
            diff_l_reg <= DIFF_W'(err_l) - DIFF_W'(last_err_l_reg);
            diff_r_reg <= DIFF_W'(err_r) - DIFF_W'(last_err_r_reg);
        end
        prod_reg <= mul_res;
        case (cmd.du_op)
            DU_LOAD_L: du_l_reg <= prod_reg[ACC_W-1:0];
            DU_ADD_L:  du_l_reg <= du_l_reg + prod_reg[ACC_W-1:0];
            DU_LOAD_R: du_r_reg <= prod_reg[ACC_W-1:0];
            DU_ADD_R:  du_r_reg <= du_r_reg + prod_reg[ACC_W-1:0];
            default: begin
                du_l_reg <= du_l_reg;
                du_r_reg <= du_r_reg;
            end
        endcase
        if (cmd.load_out) begin
            drive_l_reg <= accum_l_reg[DRIVE_W-1:0];
            drive_r_reg <= accum_r_reg[DRIVE_W-1:0];
            goal_l_reg  <= target_l_reg;
            goal_r_reg  <= target_r_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quo_reg        <= '0;
            target_l_reg   <= '0;
            target_r_reg   <= '0;
            last_err_l_reg <= '0;
            last_err_r_reg <= '0;
            accum_l_reg    <= '0;
            accum_r_reg    <= '0;
        end else begin
            if (cmd.ofs_mul) begin
                quo_reg <= '0;
            end else if (cmd.div_step) begin
                quo_reg <= quo_reg + 1'b1;
            end
            if (cmd.set_target) begin
                unique case (mode_reg)
                    MODE_STOP: begin
                        target_l_reg <= '0;
                        target_r_reg <= '0;
                    end
                    MODE_REVERSE: begin
                        target_l_reg <= -$signed(GOAL_W'(cfg.base_speed));
                        target_r_reg <= -$signed(GOAL_W'(cfg.base_speed));
                    end
                    MODE_FORWARD: begin
                        target_l_reg <= clamp_speed(tl_raw);
                        target_r_reg <= clamp_speed(tr_raw);
                    end
                    MODE_HOLD: begin
                        target_l_reg <= target_l_reg;
                        target_r_reg <= target_r_reg;
                    end
                endcase
            end
            if (cmd.calc_err) begin
                last_err_l_reg <= err_l;
                last_err_r_reg <= err_r;
            end
            if (cmd.acc_upd) begin
                accum_l_reg <= acc_clamp(accum_l_reg, du_l_reg, lim_s);
                accum_r_reg <= acc_clamp(accum_r_reg, du_r_reg, lim_s);
            end
        end
    end

    assign m_drive_left  = drive_l_reg;
    assign m_drive_right = drive_r_reg;
    assign m_goal_left   = goal_l_reg;
    assign m_goal_right  = goal_r_reg;

    `DWPI_ASSERT_ALWAYS(a_quo_bound, aclk, aresetn, quo_reg <= QUO_W'(OFFSET_MAX), "offset quotient past its clamp")

    `DWPI_ASSERT_NEXT(a_acc_limit, aclk, aresetn, cmd.acc_upd, (accum_l_reg <= lim_s) && (accum_l_reg >= -lim_s) && (accum_r_reg <= lim_s) && (accum_r_reg >= -lim_s), "accumulator outside drive limit")

    `DWPI_ASSERT_NEXT(a_fwd_target, aclk, aresetn, cmd.set_target && (mode_reg == MODE_FORWARD), (target_l_reg >= GOAL_W'(SPEED_MIN)) && (target_l_reg <= GOAL_W'(SPEED_MAX)) && (target_r_reg >= GOAL_W'(SPEED_MIN)) && (target_r_reg <= GOAL_W'(SPEED_MAX)), "forward target outside speed window")

endmodule
